[hdl/sparse_polynomial_evaluator_defines.svh]
// ----------------------------------------------------------------------------
// Sparse polynomial evaluator: assertion macros
// Shared checking helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_EVALUATOR_DEFINES_SVH
`define SPARSE_POLYNOMIAL_EVALUATOR_DEFINES_SVH

// Same-cycle implication
`define SPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/spe_pkg.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial evaluator package
// Beat types, operation codes, Q16.16 constants and sequencer states.
// ----------------------------------------------------------------------------
package spe_pkg;

  localparam int POW_W = 4;

  // operation codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Q16.16 constants
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] Q_HALF = 64'sd32768;

  typedef struct packed {
    logic                func;
    logic [2:0]          term_index;
    logic signed [31:0]  coefficient;
    logic [POW_W-1:0]    power;
    logic signed [31:0]  x_value;
  } spe_in_t;

  typedef struct packed {
    logic signed [31:0]  y_value;
    logic                overflow;
  } spe_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_MUL,
    ST_NORM,
    ST_ADD,
    ST_DONE
  } spe_state_t;

endpackage

[hdl/sparse_polynomial_evaluator.sv]
// Load beat: the next beat is taken on the following cycle.
// Evaluate beat: each term is read from the table and built on the one shared
// 32x32 multiplier (a multiply and a round/saturate step per product), first
// by x for each power step, then by the coefficient. One beat at a time.
// Reset (synchronous, rst_n low): idle, no result pending, num_terms = 0;
// the term table is not cleared.
// ----------------------------------------------------------------------------
// Sparse polynomial evaluator
// Term table in a small memory; terms are summed with one shared Q16.16
// multiplier under a sequencer, with saturation and an overflow flag.
// ----------------------------------------------------------------------------
`include "sparse_polynomial_evaluator_defines.svh"

module sparse_polynomial_evaluator #(
  parameter int MAX_TERMS = 8,
  parameter int MAX_POWER = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_we,
  input  logic [3:0]       cfg_wdata,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  spe_pkg::spe_in_t in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output spe_pkg::spe_out_t out_data
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);

  // state and datapath registers
  spe_pkg::spe_state_t       state_r, state_nxt;
  logic [3:0]                num_terms_r;
  logic signed [31:0]        x_r, x_nxt;
  logic signed [31:0]        coef_r, coef_nxt;
  logic signed [31:0]        r_r, r_nxt;
  logic signed [31:0]        term_r, term_nxt;
  logic signed [31:0]        sum_r, sum_nxt;
  logic                      flag_r, flag_nxt;
  logic [spe_pkg::POW_W-1:0] pcnt_r, pcnt_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic [CW-1:0]             n_r, n_nxt;
  logic signed [63:0]        prod_r, prod_nxt;
  logic                      out_valid_r, out_valid_nxt;
  spe_pkg::spe_out_t         out_data_r, out_data_nxt;

  // term memory
  logic signed [31:0]        coef_mem [MAX_TERMS];
  logic [spe_pkg::POW_W-1:0] pow_mem  [MAX_TERMS];
  logic signed [31:0]        rd_coef_r;
  logic [spe_pkg::POW_W-1:0] rd_pow_r;

  logic                      in_accept;
  logic                      out_free;
  logic                      mem_we;
  logic [spe_pkg::POW_W-1:0] wr_pow;
  logic [CW-1:0]             n_clamp;
  logic signed [31:0]        mul_b;
  logic signed [63:0]        mul_p;
  logic signed [63:0]        rnd;
  logic                      norm_ovf;
  logic signed [31:0]        norm_q;
  logic signed [32:0]        add_s;
  logic                      add_ovf;
  logic signed [31:0]        add_q;

  assign in_stall  = (state_r != spe_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // load decode: out-of-range slots are dropped, powers clamp
  assign mem_we = in_accept && (in_data.func == spe_pkg::FUNC_LOAD) &&
                  (int'(in_data.term_index) < MAX_TERMS);
  assign wr_pow = (int'(in_data.power) > MAX_POWER) ?
                  spe_pkg::POW_W'(MAX_POWER) : in_data.power;
  assign n_clamp = CW'((int'(num_terms_r) > MAX_TERMS) ? MAX_TERMS : int'(num_terms_r));

  // shared multiplier: r * x while power steps remain, else r * coefficient
  assign mul_b = (pcnt_r != '0) ? x_r : coef_r;
  assign mul_p = r_r * mul_b;

  // round to nearest, floor shift, saturate
  assign rnd      = prod_r + spe_pkg::Q_HALF;
  assign norm_ovf = !((&rnd[63:47]) || (~|rnd[63:47]));
  assign norm_q   = norm_ovf ? (rnd[63] ? spe_pkg::Q_MIN : spe_pkg::Q_MAX) : rnd[47:16];

  // saturating accumulate
  assign add_s   = {sum_r[31], sum_r} + {term_r[31], term_r};
  assign add_ovf = (add_s[32] != add_s[31]);
  assign add_q   = add_ovf ? (add_s[32] ? spe_pkg::Q_MIN : spe_pkg::Q_MAX) : add_s[31:0];

  // memory: write on load beats, registered read at the term counter
  always_ff @(posedge clk) begin
    if (mem_we) begin
      coef_mem[AW'(in_data.term_index)] <= in_data.coefficient;
      pow_mem[AW'(in_data.term_index)]  <= wr_pow;
    end
    rd_coef_r <= coef_mem[idx_r[AW-1:0]];
    rd_pow_r  <= pow_mem[idx_r[AW-1:0]];
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    coef_nxt      = coef_r;
    r_nxt         = r_r;
    term_nxt      = term_r;
    sum_nxt       = sum_r;
    flag_nxt      = flag_r;
    pcnt_nxt      = pcnt_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      spe_pkg::ST_IDLE: begin
        if (in_accept && (in_data.func == spe_pkg::FUNC_EVAL)) begin
          x_nxt     = in_data.x_value;
          sum_nxt   = '0;
          flag_nxt  = 1'b0;
          idx_nxt   = '0;
          n_nxt     = n_clamp;
          state_nxt = (n_clamp == '0) ? spe_pkg::ST_DONE : spe_pkg::ST_READ;
        end
      end
      spe_pkg::ST_READ: begin
        state_nxt = spe_pkg::ST_FETCH;
      end
      spe_pkg::ST_FETCH: begin
        coef_nxt  = rd_coef_r;
        pcnt_nxt  = rd_pow_r;
        r_nxt     = spe_pkg::Q_ONE;
        state_nxt = spe_pkg::ST_MUL;
      end
      spe_pkg::ST_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = spe_pkg::ST_NORM;
      end
      spe_pkg::ST_NORM: begin
        flag_nxt = flag_r || norm_ovf;
        if (pcnt_r != '0) begin
          r_nxt     = norm_q;
          pcnt_nxt  = pcnt_r - 1'b1;
          state_nxt = spe_pkg::ST_MUL;
        end else begin
          term_nxt  = norm_q;
          state_nxt = spe_pkg::ST_ADD;
        end
      end
      spe_pkg::ST_ADD: begin
        sum_nxt   = add_q;
        flag_nxt  = flag_r || add_ovf;
        idx_nxt   = CW'(idx_r + 1'b1);
        state_nxt = (CW'(idx_r + 1'b1) == n_r) ? spe_pkg::ST_DONE : spe_pkg::ST_READ;
      end
      spe_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.y_value  = sum_r;
          out_data_nxt.overflow = flag_r;
          state_nxt             = spe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spe_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath registers; only the term count and the result valid flag reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_terms_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_terms_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
    x_r        <= x_nxt;
    coef_r     <= coef_nxt;
    r_r        <= r_nxt;
    term_r     <= term_nxt;
    sum_r      <= sum_nxt;
    flag_r     <= flag_nxt;
    pcnt_r     <= pcnt_nxt;
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  `SPE_ASSERT_NEXT(a_eval_leaves_idle, in_accept && (in_data.func == spe_pkg::FUNC_EVAL), state_r != spe_pkg::ST_IDLE, "evaluate beat did not start the sequencer")
  `SPE_ASSERT_NOW(a_idx_in_range, state_r == spe_pkg::ST_ADD, idx_r < n_r, "term counter ran past the term count")
  `SPE_ASSERT_NOW(a_pow_in_range, state_r == spe_pkg::ST_MUL, int'(pcnt_r) <= MAX_POWER, "power count above the limit")
  `SPE_ASSERT_NEXT(a_done_posts, (state_r == spe_pkg::ST_DONE) && out_free, out_valid_r && (state_r == spe_pkg::ST_IDLE), "finished evaluation did not post a result")

endmodule
